@@ src/swap_frame_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// swap_frame_allocator assertion macros
// shared property forms for the allocator checks
// ----------------------------------------------------------------------------
`ifndef SWAP_FRAME_ALLOCATOR_ASSERT_SVH
`define SWAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SFA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("swap_frame_allocator check failed");

// next-cycle implication, disabled while in reset
`define SFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("swap_frame_allocator check failed");

`endif

@@ src/sfa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfa_pkg
// types and constants shared by the swap frame allocator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

    localparam int FRAMES      = 16;
    localparam int PAGES       = 32;
    localparam int PROCESSES   = 8;

    localparam int FRAME_W     = $clog2(FRAMES);
    localparam int PID_W       = 4;
    localparam int PAGE_W      = 5;
    localparam int ADDR_W      = 32;
    localparam int PROC_IDX_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int FRAME_SHIFT = 12;

    localparam logic [ADDR_W-1:0] POOL_BASE = 32'h2002_0000;

    localparam logic ACT_FAULT     = 1'b0;
    localparam logic ACT_TERMINATE = 1'b1;

    // packed widths of the stream payloads
    localparam int S_DATA_W = ((PID_W + PAGE_W + 7) / 8) * 8;
    localparam int M_FIELD_W = FRAME_W + ADDR_W + 1 + PID_W + PAGE_W;
    localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // scan unit status back to the sequencer
    typedef struct packed {
        logic               done;
        logic [FRAME_W-1:0] chosen;
    } sfa_scan_status_t;

    // owner table write port
    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] addr;
        logic [PID_W-1:0]   data;
    } sfa_owner_wr_t;

    // step to the next frame, circularly
    function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] f);
        logic [FRAME_W-1:0] r;
        if (f == FRAME_W'(FRAMES - 1)) begin
            r = '0;
        end else begin
            r = f + FRAME_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/sfa_ram.sv @@
// ----------------------------------------------------------------------------
// sfa_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/sfa_owner_tbl.sv @@
// ----------------------------------------------------------------------------
// sfa_owner_tbl
// frame owner table, cleared to free on reset, one read and one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_owner_tbl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire sfa_pkg::sfa_owner_wr_t           wr,
    input  wire logic [sfa_pkg::FRAME_W-1:0]      rd_addr,
    output logic      [sfa_pkg::PID_W-1:0]        rd_data
);

    logic [sfa_pkg::PID_W-1:0] owner_reg [sfa_pkg::FRAMES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sfa_pkg::FRAMES; i++) begin
                owner_reg[i] <= '0;
            end
        end else if (wr.en) begin
            owner_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = owner_reg[rd_addr];

endmodule

`default_nettype wire

@@ src/sfa_scan.sv @@
// ----------------------------------------------------------------------------
// sfa_scan
// circular free-frame search, one table entry per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [sfa_pkg::FRAME_W-1:0]   start_frame,
    input  wire logic [sfa_pkg::PID_W-1:0]     owner,
    output logic      [sfa_pkg::FRAME_W-1:0]   probe,
    output sfa_pkg::sfa_scan_status_t          status
);

    logic                          busy_reg;
    logic [sfa_pkg::FRAME_W-1:0]   ptr_reg;
    logic [sfa_pkg::FRAME_W-1:0]   cnt_reg;
    logic [sfa_pkg::FRAME_W-1:0]   base_reg;
    logic                          is_free;
    logic                          at_end;

    assign is_free = (owner == '0);
    assign at_end  = (cnt_reg == sfa_pkg::FRAME_W'(sfa_pkg::FRAMES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (status.done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ptr_reg  <= start_frame;
            base_reg <= start_frame;
            cnt_reg  <= '0;
        end else if (busy_reg && !status.done) begin
            ptr_reg <= sfa_pkg::next_frame(ptr_reg);
            cnt_reg <= cnt_reg + sfa_pkg::FRAME_W'(1);
        end
    end

    // table full: fall back to the frame after the last one chosen
    always_comb begin
        status.done   = busy_reg && (is_free || at_end);
        status.chosen = is_free ? ptr_reg : sfa_pkg::next_frame(base_reg);
    end

    assign probe = ptr_reg;

endmodule

`default_nettype wire

@@ src/swap_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// swap_frame_allocator
// round-robin swap pool frame allocator with victim writeback reporting
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (lsb first)                         tuser
// s_*       in   process_id[3:0], page_index[8:4]                 action
// m_*       out  frame_number[3:0], frame_address[35:4],          error
//                writeback[36], victim_process[40:37],
//                victim_page[45:41]
//
// a page fault passes through the scan, read, update and output states; the
// scan unit visits 1..16 owner table entries on the way (one per cycle)
// terminate and invalid requests go from idle straight to the output state
// one request at a time: s_tready is high only while the sequencer is idle
// a finished result waits in the output register; the next request is taken
// meanwhile, and its result waits in the output state until m_tready frees it
// synchronous active-low reset frees all frames, clears alive bits and
// last frame; page table entries are undefined until written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "swap_frame_allocator_assert.svh"

module swap_frame_allocator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // request channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sfa_pkg::S_DATA_W-1:0]   s_tdata,   // process_id, page_index
    input  wire logic                           s_tuser,   // action
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [sfa_pkg::M_DATA_W-1:0]   m_tdata,   // frame_number, frame_address,
                                                           // writeback, victim_process,
                                                           // victim_page
    output logic                                m_tuser    // error
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_READ = 5'b00100,
        S_UPD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // request fields
    logic [sfa_pkg::PID_W-1:0]  in_pid;
    logic [sfa_pkg::PAGE_W-1:0] in_page;
    logic                       in_action;
    logic                       s_fire;
    logic                       pid_ok;
    logic                       page_ok;

    assign in_pid    = s_tdata[sfa_pkg::PID_W-1:0];
    assign in_page   = s_tdata[sfa_pkg::PID_W +: sfa_pkg::PAGE_W];
    assign in_action = s_tuser;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign pid_ok    = (in_pid != '0) &&
                       (in_pid <= sfa_pkg::PID_W'(sfa_pkg::PROCESSES));
    assign page_ok   = ({1'b0, in_page} < (sfa_pkg::PAGE_W + 1)'(sfa_pkg::PAGES));

    // working registers for the request in flight, alive bits and last chosen frame
    logic [sfa_pkg::PID_W-1:0]      pid_reg;
    logic [sfa_pkg::PAGE_W-1:0]     page_reg;
    logic                           fault_ok_reg;
    logic                           err_reg;
    logic [sfa_pkg::FRAME_W-1:0]    chosen_reg;
    logic [sfa_pkg::PID_W-1:0]      vproc_reg;
    logic [sfa_pkg::PAGE_W-1:0]     vpage_reg;
    logic                           wb_reg;
    logic [sfa_pkg::PROCESSES-1:0]  alive_reg;
    logic [sfa_pkg::FRAME_W-1:0]    last_frame_reg;

    // output register
    logic                           m_tvalid_reg;
    logic [sfa_pkg::M_DATA_W-1:0]   m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           out_load;

    // scan unit and tables
    sfa_pkg::sfa_scan_status_t      scan_status;
    logic [sfa_pkg::FRAME_W-1:0]    scan_probe;
    logic                           scan_start;
    logic [sfa_pkg::FRAME_W-1:0]    owner_rd_addr;
    logic [sfa_pkg::PID_W-1:0]      owner_rd_data;
    sfa_pkg::sfa_owner_wr_t         owner_wr;
    logic [sfa_pkg::PAGE_W-1:0]     page_rd_data;
    logic                           upd_en;

    assign scan_start    = s_fire && (in_action == sfa_pkg::ACT_FAULT) && pid_ok && page_ok;
    // single read port: scan pointer while searching, chosen frame afterwards
    assign owner_rd_addr = (state_reg == S_SCAN) ? scan_probe : chosen_reg;
    assign upd_en        = (state_reg == S_UPD);

    always_comb begin
        owner_wr.en   = upd_en;
        owner_wr.addr = chosen_reg;
        owner_wr.data = pid_reg;
    end

    sfa_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (scan_start),
        .start_frame (last_frame_reg),
        .owner       (owner_rd_data),
        .probe       (scan_probe),
        .status      (scan_status)
    );

    sfa_owner_tbl u_owner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (owner_wr),
        .rd_addr (owner_rd_addr),
        .rd_data (owner_rd_data)
    );

    // page held in each frame; its read is used only while the frame is occupied
    sfa_ram #(
        .WIDTH (sfa_pkg::PAGE_W),
        .DEPTH (sfa_pkg::FRAMES)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (upd_en),
        .wr_addr (chosen_reg),
        .wr_data (page_reg),
        .rd_en   (state_reg == S_READ),
        .rd_addr (chosen_reg),
        .rd_data (page_rd_data)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = scan_start ? S_SCAN : S_OUT;
                end
            end
            S_SCAN: begin
                if (scan_status.done) begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // allocator state: alive bits and round-robin position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg      <= '0;
            last_frame_reg <= '0;
        end else begin
            if (s_fire && pid_ok && (in_action == sfa_pkg::ACT_TERMINATE)) begin
                alive_reg[sfa_pkg::PROC_IDX_W'(in_pid - sfa_pkg::PID_W'(1))] <= 1'b0;
            end
            if (upd_en) begin
                alive_reg[sfa_pkg::PROC_IDX_W'(pid_reg - sfa_pkg::PID_W'(1))] <= 1'b1;
                last_frame_reg <= chosen_reg;
            end
        end
    end

    // per-request working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pid_reg      <= in_pid;
            page_reg     <= in_page;
            fault_ok_reg <= scan_start;
            // bad process id, or a fault on a page past the table
            err_reg      <= !pid_ok || ((in_action == sfa_pkg::ACT_FAULT) && !page_ok);
            chosen_reg   <= '0;
            vproc_reg    <= '0;
            vpage_reg    <= '0;
            wb_reg       <= 1'b0;
        end
        if ((state_reg == S_SCAN) && scan_status.done) begin
            chosen_reg <= scan_status.chosen;
        end
        if (state_reg == S_READ) begin
            vproc_reg <= owner_rd_data;
            // writeback only when the previous owner is still alive
            wb_reg    <= (owner_rd_data != '0) &&
                         alive_reg[sfa_pkg::PROC_IDX_W'(owner_rd_data - sfa_pkg::PID_W'(1))];
        end
        if (upd_en) begin
            vpage_reg <= (vproc_reg != '0) ? page_rd_data : '0;
        end
    end

    // result assembly
    logic [sfa_pkg::ADDR_W-1:0] frame_addr;

    assign frame_addr = fault_ok_reg
        ? sfa_pkg::POOL_BASE + (sfa_pkg::ADDR_W'(chosen_reg) << sfa_pkg::FRAME_SHIFT)
        : '0;

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= sfa_pkg::M_DATA_W'({vpage_reg, vproc_reg, wb_reg,
                                               frame_addr, chosen_reg});
            m_tuser_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `SFA_ASSERT_NEXT(a_out_load_shows, aclk, aresetn,
        (state_reg == S_OUT) && !m_tvalid_reg, m_tvalid_reg)
    `SFA_ASSERT_NOW(a_wb_has_owner, aclk, aresetn,
        m_tvalid_reg && m_tdata_reg[sfa_pkg::FRAME_W + sfa_pkg::ADDR_W],
        m_tdata_reg[sfa_pkg::FRAME_W + sfa_pkg::ADDR_W + 1 +: sfa_pkg::PID_W] != '0)
    `SFA_ASSERT_NOW(a_err_empty, aclk, aresetn,
        m_tvalid_reg && m_tuser_reg,
        m_tdata_reg == '0)
    `SFA_ASSERT_NOW(a_scan_only_on_fault, aclk, aresetn,
        scan_status.done, state_reg == S_SCAN)

endmodule

`default_nettype wire
